// File: src/fircen_pkg.sv
package fircen_pkg;

    localparam int MAX_TAPS_DEFAULT = 16;
    localparam int COEF_TAPS        = 16;
    localparam int COEF_IDX_W       = $clog2(COEF_TAPS);

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int POS_W       = 32;
    localparam int PROD_W      = 32;
    localparam int FILT_W      = 16;
    localparam int TAP_COUNT_W = 5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_0    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_1    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_2    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_3    = 3'd4;

    localparam int FRAC_BITS  = 15;
    localparam int ROUND_HALF = 16384;
    localparam int FILT_MAX   = 32767;
    localparam int FILT_MIN   = -32768;

    typedef logic [COEF_TAPS-1:0][COEF_W-1:0] coef_bank_t;

    typedef struct packed {
        logic shift;
        logic lo_sel;
        logic hi_sel;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [FILT_W-1:0] filtered;
        logic signed [POS_W-1:0]  center_position;
    } result_t;

    function automatic int tree_levels(input int n);
        int levels;
        levels = $clog2(n);
        if (levels < 1)
        begin
            levels = 1;
        end
        return levels;
    endfunction

endpackage

// File: src/fir_filter_with_center_abscissa.sv
// Streaming FIR filter over (abscissa, sample) points: a row of MAX_TAPS cells holds the
// window, each with its own 16x16 multiplier, feeding a registered adder tree of
// clog2(MAX_TAPS) levels (at least one). One point is taken every cycle while item_stall
// is low. A result passes the window cells, the product register, the tree levels and
// the result queue. The queue holds TREE_LEVELS + 4 results; item_stall rises only when
// that many results are accepted but not yet taken. Points before the window has filled,
// after a first_in_set, give no result.
module fir_filter_with_center_abscissa #(
    parameter int MAX_TAPS = fircen_pkg::MAX_TAPS_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [fircen_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [fircen_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                     item_valid,
    output logic                                     item_stall,
    input  logic                                     first_in_set,
    input  logic signed [fircen_pkg::POS_W-1:0]      x_position,
    input  logic signed [fircen_pkg::SAMPLE_W-1:0]   sample,
    output logic                                     result_valid,
    input  logic                                     result_stall,
    output logic signed [fircen_pkg::FILT_W-1:0]     filtered,
    output logic signed [fircen_pkg::POS_W-1:0]      center_position
);

    localparam int LEN_W       = $clog2(MAX_TAPS + 1);
    localparam int TREE_LEVELS = fircen_pkg::tree_levels(MAX_TAPS);
    localparam int SUM_W       = fircen_pkg::PROD_W + TREE_LEVELS;
    localparam int RND_W       = SUM_W + 1;
    localparam int FIFO_DEPTH  = TREE_LEVELS + 4;
    localparam int CRED_W      = $clog2(FIFO_DEPTH + 1);

    logic [fircen_pkg::TAP_COUNT_W-1:0] tap_count_reg;
    fircen_pkg::coef_bank_t             coef_reg;
    logic [LEN_W-1:0]                   fill_reg, fill_next;
    logic                               a_vld_reg;
    logic                               p_vld_reg;
    logic [CRED_W-1:0]                  cred_reg, cred_next;

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_m1;
    logic [LEN_W-1:0] lo_idx;
    logic [LEN_W-1:0] hi_idx;
    logic             item_accept;
    logic             has_result;
    logic             result_pop;

    fircen_pkg::cell_ctrl_t                  ctrl        [MAX_TAPS];
    logic signed [fircen_pkg::SAMPLE_W-1:0]  sample_link [MAX_TAPS];
    logic signed [fircen_pkg::POS_W-1:0]     pos_link    [MAX_TAPS];
    logic signed [fircen_pkg::COEF_W-1:0]    cell_coef   [MAX_TAPS];
    logic [LEN_W-1:0]                        coef_j      [MAX_TAPS];
    logic signed [fircen_pkg::PROD_W-1:0]    product     [MAX_TAPS];
    logic signed [fircen_pkg::POS_W-1:0]     lo_part     [MAX_TAPS];
    logic signed [fircen_pkg::POS_W-1:0]     hi_part     [MAX_TAPS];

    logic signed [fircen_pkg::POS_W-1:0] lo_pos;
    logic signed [fircen_pkg::POS_W-1:0] hi_pos;
    logic signed [fircen_pkg::POS_W:0]   center_sum;
    logic [fircen_pkg::POS_W-1:0]        center_tag;

    logic                                tree_vld;
    logic signed [SUM_W-1:0]             tree_sum;
    logic [fircen_pkg::POS_W-1:0]        tree_tag;
    logic signed [RND_W-1:0]             rnd;
    logic signed [RND_W-1:0]             quot;
    fircen_pkg::result_t                 push_res;
    fircen_pkg::result_t                 pop_res;

    assign item_accept = item_valid && !item_stall;
    assign item_stall  = (cred_reg == CRED_W'(FIFO_DEPTH));
    assign result_pop  = result_valid && !result_stall;

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            len = LEN_W'(MAX_TAPS);
        end
        else
        begin
            len = LEN_W'(tap_count_reg);
        end
        len_m1 = len - 1'b1;
        lo_idx = len_m1 >> 1;
        hi_idx = len >> 1;
    end

    always_comb
    begin
        if (first_in_set)
        begin
            fill_next = LEN_W'(1);
        end
        else if (int'(fill_reg) < MAX_TAPS)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else
        begin
            fill_next = fill_reg;
        end
        has_result = (fill_next >= len);
    end

    always_comb
    begin
        cred_next = cred_reg;
        case ({item_accept && has_result, result_pop})
            2'b10:   cred_next = cred_reg + 1'b1;
            2'b01:   cred_next = cred_reg - 1'b1;
            default: cred_next = cred_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= fircen_pkg::TAP_COUNT_W'(1);
            coef_reg      <= '0;
            fill_reg      <= '0;
            a_vld_reg     <= 1'b0;
            p_vld_reg     <= 1'b0;
            cred_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    fircen_pkg::REG_TAP_COUNT:
                        tap_count_reg <= cfg_data[fircen_pkg::TAP_COUNT_W-1:0];
                    fircen_pkg::REG_COEF_0: coef_reg[3:0]   <= cfg_data;
                    fircen_pkg::REG_COEF_1: coef_reg[7:4]   <= cfg_data;
                    fircen_pkg::REG_COEF_2: coef_reg[11:8]  <= cfg_data;
                    fircen_pkg::REG_COEF_3: coef_reg[15:12] <= cfg_data;
                    default: ;
                endcase
            end
            if (item_accept)
            begin
                fill_reg <= fill_next;
            end
            a_vld_reg <= item_accept && has_result;
            p_vld_reg <= a_vld_reg;
            cred_reg  <= cred_next;
        end
    end

    // Cell k holds the k-th newest point; coefficient len-1-k pairs with it.
    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        assign coef_j[k]       = len_m1 - LEN_W'(k);
        assign ctrl[k].shift   = item_accept;
        assign ctrl[k].lo_sel  = (lo_idx == LEN_W'(k));
        assign ctrl[k].hi_sel  = (hi_idx == LEN_W'(k));

        always_comb
        begin
            cell_coef[k] = '0;
            if ((LEN_W'(k) <= len_m1) && (int'(coef_j[k]) < fircen_pkg::COEF_TAPS))
            begin
                cell_coef[k] = coef_reg[fircen_pkg::COEF_IDX_W'(coef_j[k])];
            end
        end

        if (k == 0)
        begin : g_head
            fircen_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl[k]),
                .sample_in    (sample),
                .position_in  (x_position),
                .coef_in      (cell_coef[k]),
                .sample_out   (sample_link[k]),
                .position_out (pos_link[k]),
                .product      (product[k]),
                .lo_part      (lo_part[k]),
                .hi_part      (hi_part[k])
            );
        end
        else
        begin : g_body
            fircen_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl[k]),
                .sample_in    (sample_link[k-1]),
                .position_in  (pos_link[k-1]),
                .coef_in      (cell_coef[k]),
                .sample_out   (sample_link[k]),
                .position_out (pos_link[k]),
                .product      (product[k]),
                .lo_part      (lo_part[k]),
                .hi_part      (hi_part[k])
            );
        end
    end

    always_comb
    begin
        lo_pos = '0;
        hi_pos = '0;
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            lo_pos = lo_pos | lo_part[k];
            hi_pos = hi_pos | hi_part[k];
        end
        center_sum = (fircen_pkg::POS_W + 1)'(lo_pos) + (fircen_pkg::POS_W + 1)'(hi_pos);
        center_tag = center_sum[fircen_pkg::POS_W:1];
    end

    fircen_tree #(
        .N     (MAX_TAPS),
        .IN_W  (fircen_pkg::PROD_W),
        .OUT_W (SUM_W),
        .TAG_W (fircen_pkg::POS_W)
    ) u_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (p_vld_reg),
        .leaf    (product),
        .tag_in  (center_tag),
        .out_vld (tree_vld),
        .sum     (tree_sum),
        .tag_out (tree_tag)
    );

    always_comb
    begin
        rnd  = RND_W'(tree_sum) + RND_W'(fircen_pkg::ROUND_HALF);
        quot = rnd >>> fircen_pkg::FRAC_BITS;
        if (quot > fircen_pkg::FILT_MAX)
        begin
            push_res.filtered = fircen_pkg::FILT_W'(fircen_pkg::FILT_MAX);
        end
        else if (quot < fircen_pkg::FILT_MIN)
        begin
            push_res.filtered = fircen_pkg::FILT_W'(fircen_pkg::FILT_MIN);
        end
        else
        begin
            push_res.filtered = quot[fircen_pkg::FILT_W-1:0];
        end
        push_res.center_position = tree_tag;
    end

    fircen_fifo #(
        .WIDTH ($bits(fircen_pkg::result_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tree_vld),
        .push_data (push_res),
        .pop       (result_pop),
        .pop_data  (pop_res),
        .not_empty (result_valid)
    );

    assign filtered        = pop_res.filtered;
    assign center_position = pop_res.center_position;

    a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cred_reg <= CRED_W'(FIFO_DEPTH))
        else $error("outstanding request count beyond queue depth");

    a_valid_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (cred_reg != '0))
        else $error("result offered with no outstanding request");

    a_first_restarts_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && first_in_set) |=> (fill_reg == LEN_W'(1)))
        else $error("fill count not restarted by first point of a series");

endmodule

// File: src/fircen_cell.sv
module fircen_cell (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  fircen_pkg::cell_ctrl_t                   ctrl,
    input  logic signed [fircen_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic signed [fircen_pkg::POS_W-1:0]      position_in,
    input  logic signed [fircen_pkg::COEF_W-1:0]     coef_in,
    output logic signed [fircen_pkg::SAMPLE_W-1:0]   sample_out,
    output logic signed [fircen_pkg::POS_W-1:0]      position_out,
    output logic signed [fircen_pkg::PROD_W-1:0]     product,
    output logic signed [fircen_pkg::POS_W-1:0]      lo_part,
    output logic signed [fircen_pkg::POS_W-1:0]      hi_part
);

    logic signed [fircen_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [fircen_pkg::POS_W-1:0]    position_reg;
    logic signed [fircen_pkg::COEF_W-1:0]   coef_reg;
    logic signed [fircen_pkg::PROD_W-1:0]   product_reg;
    logic signed [fircen_pkg::POS_W-1:0]    lo_reg;
    logic signed [fircen_pkg::POS_W-1:0]    hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg   <= '0;
            position_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            sample_reg   <= sample_in;
            position_reg <= position_in;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg    <= coef_in;
        product_reg <= fircen_pkg::PROD_W'(sample_reg * coef_reg);
        lo_reg      <= ctrl.lo_sel ? position_reg : '0;
        hi_reg      <= ctrl.hi_sel ? position_reg : '0;
    end

    assign sample_out   = sample_reg;
    assign position_out = position_reg;
    assign product      = product_reg;
    assign lo_part      = lo_reg;
    assign hi_part      = hi_reg;

endmodule

// File: src/fircen_tree.sv
module fircen_tree #(
    parameter int N     = fircen_pkg::MAX_TAPS_DEFAULT,
    parameter int IN_W  = fircen_pkg::PROD_W,
    parameter int OUT_W = fircen_pkg::PROD_W + fircen_pkg::tree_levels(N),
    parameter int TAG_W = fircen_pkg::POS_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  logic signed [IN_W-1:0]  leaf [N],
    input  logic [TAG_W-1:0]        tag_in,
    output logic                    out_vld,
    output logic signed [OUT_W-1:0] sum,
    output logic [TAG_W-1:0]        tag_out
);

    localparam int LEVELS = fircen_pkg::tree_levels(N);
    localparam int NP     = 1 << LEVELS;

    logic signed [OUT_W-1:0] leaf_ext [NP];
    logic signed [OUT_W-1:0] node_reg [1:NP-1];
    logic [TAG_W-1:0]        tag_reg  [LEVELS];
    logic [LEVELS-1:0]       vld_reg;

    for (genvar i = 0; i < NP; i++)
    begin : g_leaf
        if (i < N)
        begin : g_used
            assign leaf_ext[i] = OUT_W'(leaf[i]);
        end
        else
        begin : g_pad
            assign leaf_ext[i] = '0;
        end
    end

    for (genvar i = 1; i < NP; i++)
    begin : g_node
        if (2 * i >= NP)
        begin : g_bottom
            always_ff @(posedge clk)
            begin
                node_reg[i] <= leaf_ext[2*i-NP] + leaf_ext[2*i+1-NP];
            end
        end
        else
        begin : g_inner
            always_ff @(posedge clk)
            begin
                node_reg[i] <= node_reg[2*i] + node_reg[2*i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= tag_in;
        for (int l = 1; l < LEVELS; l++)
        begin
            tag_reg[l] <= tag_reg[l-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= LEVELS'({vld_reg, in_vld});
        end
    end

    assign out_vld = vld_reg[LEVELS-1];
    assign sum     = node_reg[1];
    assign tag_out = tag_reg[LEVELS-1];

endmodule

// File: src/fircen_fifo.sv
module fircen_fifo #(
    parameter int WIDTH = $bits(fircen_pkg::result_t),
    parameter int DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign pop_data  = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);

endmodule

// File: test/fir_filter_with_center_abscissa_test.sv
module fir_filter_with_center_abscissa_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS           = fircen_pkg::MAX_TAPS_DEFAULT;
    localparam int PHASES         = 26;
    localparam int PHASE_POINTS   = 50;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [fircen_pkg::CFG_INDEX_W-1:0] COEF_REGS [4] = '{
        fircen_pkg::REG_COEF_0, fircen_pkg::REG_COEF_1,
        fircen_pkg::REG_COEF_2, fircen_pkg::REG_COEF_3
    };

    typedef enum logic { ROW_CFG, ROW_POINT } row_kind_t;

    typedef struct {
        row_kind_t                                kind;
        logic [fircen_pkg::CFG_INDEX_W-1:0]       index;
        logic [fircen_pkg::CFG_DATA_W-1:0]        data;
        logic                                     first;
        logic signed [fircen_pkg::POS_W-1:0]      x;
        logic signed [fircen_pkg::SAMPLE_W-1:0]   s;
        bit                                       typed;
        fircen_pkg::result_t                      want;
    } stim_row_t;

    logic                                     clk = 1'b0;
    logic                                     rst_n = 1'b0;
    logic                                     cfg_write = 1'b0;
    logic [fircen_pkg::CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [fircen_pkg::CFG_DATA_W-1:0]        cfg_data = '0;
    logic                                     item_valid = 1'b0;
    logic                                     item_stall;
    logic                                     first_in_set = 1'b0;
    logic signed [fircen_pkg::POS_W-1:0]      x_position = '0;
    logic signed [fircen_pkg::SAMPLE_W-1:0]   sample = '0;
    logic                                     result_valid;
    logic                                     result_stall = 1'b0;
    logic signed [fircen_pkg::FILT_W-1:0]     filtered;
    logic signed [fircen_pkg::POS_W-1:0]      center_position;

    logic [fircen_pkg::TAP_COUNT_W-1:0]       tap_setting;
    logic [fircen_pkg::CFG_DATA_W-1:0]        coef_setting [4];
    logic signed [fircen_pkg::SAMPLE_W-1:0]   sample_hist [TAPS];
    logic signed [fircen_pkg::POS_W-1:0]      pos_hist [TAPS];
    int unsigned                              fill_level;

    fircen_pkg::result_t                      awaited_outputs [$];
    stim_row_t                                directed_rows [$];

    int send_idle_pct = 33;
    int recv_idle_pct = 52;
    int errors = 0;
    int points_sent = 0;
    int results_checked = 0;
    int register_writes = 0;
    int idle_cycles = 0;

    fir_filter_with_center_abscissa dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .first_in_set    (first_in_set),
        .x_position      (x_position),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .filtered        (filtered),
        .center_position (center_position)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void reset_window();
        tap_setting = 1;
        fill_level  = 0;
        for (int i = 0; i < 4; i++)
        begin
            coef_setting[i] = '0;
        end
        for (int i = 0; i < TAPS; i++)
        begin
            sample_hist[i] = '0;
            pos_hist[i]    = '0;
        end
    endfunction

    function automatic void apply_register(input logic [fircen_pkg::CFG_INDEX_W-1:0] idx,
                                           input logic [fircen_pkg::CFG_DATA_W-1:0] data);
        unique case (idx)
            fircen_pkg::REG_TAP_COUNT:
                tap_setting = data[fircen_pkg::TAP_COUNT_W-1:0];
            fircen_pkg::REG_COEF_0: coef_setting[0] = data;
            fircen_pkg::REG_COEF_1: coef_setting[1] = data;
            fircen_pkg::REG_COEF_2: coef_setting[2] = data;
            fircen_pkg::REG_COEF_3: coef_setting[3] = data;
            default:                ;
        endcase
    endfunction

    // shift the point in and, once the window holds len points, form the weighted sum and the centre abscissa
    function automatic bit advance_window(input logic f,
                                          input logic signed [fircen_pkg::POS_W-1:0] x,
                                          input logic signed [fircen_pkg::SAMPLE_W-1:0] s,
                                          output fircen_pkg::result_t res);
        int                                  len;
        int                                  half;
        int                                  j;
        longint                              acc;
        longint                              rounded;
        longint                              pair_sum;
        logic signed [fircen_pkg::COEF_W-1:0] c;
        res = '0;
        if (f)
        begin
            fill_level = 0;
        end
        for (j = TAPS - 1; j > 0; j--)
        begin
            sample_hist[j] = sample_hist[j-1];
            pos_hist[j]    = pos_hist[j-1];
        end
        sample_hist[0] = s;
        pos_hist[0]    = x;
        if (fill_level < TAPS)
        begin
            fill_level++;
        end
        len = int'(tap_setting);
        if (len < 1)
        begin
            len = 1;
        end
        if (len > TAPS)
        begin
            len = TAPS;
        end
        if (fill_level < len)
        begin
            return 1'b0;
        end
        acc = 0;
        for (j = 0; j < len; j++)
        begin
            c = (j < fircen_pkg::COEF_TAPS) ? coef_setting[j >> 2][16 * (j % 4) +: 16] : '0;
            acc += longint'(c) * longint'(sample_hist[len - 1 - j]);
        end
        rounded = (acc + fircen_pkg::ROUND_HALF) >>> fircen_pkg::FRAC_BITS;
        if (rounded > fircen_pkg::FILT_MAX)
        begin
            rounded = fircen_pkg::FILT_MAX;
        end
        if (rounded < fircen_pkg::FILT_MIN)
        begin
            rounded = fircen_pkg::FILT_MIN;
        end
        res.filtered = rounded[fircen_pkg::FILT_W-1:0];
        half = len / 2;
        if (len % 2 == 1)
        begin
            res.center_position = pos_hist[len - 1 - half];
        end
        else
        begin
            pair_sum = longint'(pos_hist[len - 1 - half]) + longint'(pos_hist[len - half]);
            pair_sum = pair_sum >>> 1;
            res.center_position = pair_sum[fircen_pkg::POS_W-1:0];
        end
        return 1'b1;
    endfunction

    function automatic logic [fircen_pkg::COEF_W-1:0] random_coef_lane();
        case ($urandom_range(4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 2047) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_cfg(input logic [fircen_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [fircen_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row       = '{kind: ROW_CFG, default: '0};
        row.index = idx;
        row.data  = data;
        directed_rows.push_back(row);
    endtask

    task automatic add_point(input logic f,
                             input logic signed [fircen_pkg::POS_W-1:0] x,
                             input logic signed [fircen_pkg::SAMPLE_W-1:0] s,
                             input bit typed,
                             input logic signed [fircen_pkg::FILT_W-1:0] wf,
                             input logic signed [fircen_pkg::POS_W-1:0] wc);
        stim_row_t row;
        row       = '{kind: ROW_POINT, default: '0};
        row.first = f;
        row.x     = x;
        row.s     = s;
        row.typed = typed;
        row.want.filtered        = wf;
        row.want.center_position = wc;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed_rows();
        int k;
        int sv;
        add_point(1'b1, 32'sh7FFFFFFF, 16'sh7FFF, 1'b1, 16'sd0, 32'sh7FFFFFFF);
        add_point(1'b0, 32'sh80000000, 16'sh8000, 1'b1, 16'sd0, 32'sh80000000);
        add_cfg(fircen_pkg::REG_COEF_0, 64'h0000_0000_0000_8000);
        add_point(1'b0, 32'sd5, 16'sh8000, 1'b1, 16'sh7FFF, 32'sd5);
        add_point(1'b0, -32'sd7, -16'sd1, 1'b1, 16'sd1, -32'sd7);
        add_cfg(fircen_pkg::REG_COEF_0, 64'h0000_0000_0000_4000);
        add_point(1'b0, 32'sd0, 16'sd1, 1'b1, 16'sd1, 32'sd0);
        add_point(1'b0, 32'sd1, -16'sd1, 1'b1, 16'sd0, 32'sd1);
        add_cfg(fircen_pkg::REG_TAP_COUNT, 64'd2);
        add_point(1'b1, 32'sh7FFFFFFF, 16'sd100, 1'b0, '0, '0);
        add_point(1'b0, 32'sh7FFFFFFE, 16'sd200, 1'b1, 16'sd50, 32'sh7FFFFFFE);
        add_point(1'b0, 32'sh80000000, 16'sd0, 1'b1, 16'sd100, -32'sd1);
        add_point(1'b0, 32'sh80000001, 16'sd0, 1'b1, 16'sd0, 32'sh80000000);
        add_cfg(fircen_pkg::REG_TAP_COUNT, 64'd0);
        add_point(1'b0, 32'sd3, 16'sd7, 1'b1, 16'sd4, 32'sd3);
        add_cfg(fircen_pkg::REG_TAP_COUNT, 64'd31);
        add_cfg(fircen_pkg::REG_COEF_0, 64'h7FFF_8000_0001_FFFF);
        add_cfg(fircen_pkg::REG_COEF_1, 64'h1234_EDCB_4000_C000);
        add_cfg(fircen_pkg::REG_COEF_2, 64'h0800_F800_7FFF_8000);
        add_cfg(fircen_pkg::REG_COEF_3, 64'h0000_FFFF_2000_E000);
        for (k = 0; k <= TAPS; k++)
        begin
            sv = (k % 3 == 0) ? 32767 : (k % 3 == 1) ? -32768 : k * 1021;
            add_point(k == 0, 32'(k * 1000003 - 8000000), 16'(sv), 1'b0, '0, '0);
        end
    endtask

    task automatic send_point(input logic f,
                              input logic signed [fircen_pkg::POS_W-1:0] x,
                              input logic signed [fircen_pkg::SAMPLE_W-1:0] s,
                              input bit typed,
                              input fircen_pkg::result_t want);
        fircen_pkg::result_t predicted;
        bit                  produced;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        first_in_set <= f;
        x_position   <= x;
        sample       <= s;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        produced = advance_window(f, x, s, predicted);
        if (typed)
        begin
            awaited_outputs.push_back(want);
        end
        else if (produced)
        begin
            awaited_outputs.push_back(predicted);
        end
        points_sent++;
    endtask

    // drop the request, drain every awaited output, let the pipeline empty
    task automatic quiesce();
        item_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [fircen_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [fircen_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        apply_register(idx, data);
        register_writes++;
        @(posedge clk);
    endtask

    task automatic configure_phase(input int phase);
        int                                 taps;
        logic [fircen_pkg::CFG_DATA_W-1:0]  data;
        logic [fircen_pkg::CFG_DATA_W-1:0]  word;
        case (phase)
            0, 1:    taps = TAPS;
            2:       taps = 1;
            3:       taps = 0;
            4:       taps = 31;
            5:       taps = 17;
            default: taps = ($urandom_range(3) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(1, TAPS);
        endcase
        data = {$urandom, $urandom};
        data[fircen_pkg::TAP_COUNT_W-1:0] = fircen_pkg::TAP_COUNT_W'(taps);
        write_register(fircen_pkg::REG_TAP_COUNT, data);
        for (int w = 0; w < 4; w++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                case (phase)
                    0:       word[16*l +: 16] = 16'h7FFF;
                    1:       word[16*l +: 16] = 16'h8000;
                    default: word[16*l +: 16] = random_coef_lane();
                endcase
            end
            if (phase < 2 || $urandom_range(1) == 1)
            begin
                write_register(COEF_REGS[w], word);
            end
        end
    endtask

    task automatic send_random_point();
        logic                                    f;
        logic signed [fircen_pkg::POS_W-1:0]     x;
        logic signed [fircen_pkg::SAMPLE_W-1:0]  s;
        f = ($urandom_range(19) == 0);
        case ($urandom_range(7))
            0:       x = 32'sh7FFFFFFF;
            1:       x = 32'sh80000000;
            2:       x = int'($urandom_range(0, 200)) - 100;
            default: x = $urandom;
        endcase
        case ($urandom_range(7))
            0:       s = 16'sh7FFF;
            1:       s = 16'sh8000;
            default: s = 16'($urandom);
        endcase
        send_point(f, x, s, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin : check_outputs
        fircen_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_outputs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output, expected none, actual filtered=%0d center=%0d",
                         $time, filtered, center_position);
            end
            else
            begin
                want = awaited_outputs.pop_front();
                if (filtered !== want.filtered)
                begin
                    errors++;
                    $display("%0t: filtered mismatch, expected %0d, actual %0d",
                             $time, want.filtered, filtered);
                end
                if (center_position !== want.center_position)
                begin
                    errors++;
                    $display("%0t: center_position mismatch, expected %0d, actual %0d",
                             $time, want.center_position, center_position);
                end
                results_checked++;
            end
        end
        result_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin : main_flow
        int phase;
        int n;
        reset_window();
        build_directed_rows();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                quiesce();
                write_register(directed_rows[i].index, directed_rows[i].data);
            end
            else
            begin
                send_point(directed_rows[i].first, directed_rows[i].x, directed_rows[i].s,
                           directed_rows[i].typed, directed_rows[i].want);
            end
        end
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == PHASES / 3)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 33;
            end
            else if (phase == 2 * PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            quiesce();
            configure_phase(phase);
            for (n = 0; n < PHASE_POINTS; n++)
            begin
                // hold off the sender until the output side has caught up
                if (n == PHASE_POINTS / 2 && phase % 4 == 1 && awaited_outputs.size() != 0)
                begin
                    item_valid <= 1'b0;
                    while (awaited_outputs.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
                send_random_point();
            end
        end
        item_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d points and checked %0d outputs over %0d register writes,",
                 points_sent, results_checked, register_writes);
        $display("tap counts from 0 to 31, full-scale coefficients and three idling mixes.");
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
